@@ rtl/sbtr_pkg.sv @@
// Shared constants, codes and glyph scaling functions for the bitmap text renderer.
`default_nettype none

package sbtr_pkg;

  localparam int GLYPH_COUNT_DEF = 128;
  localparam int GLYPH_ROWS      = 16;
  localparam int COORD_BITS_DEF  = 16;

  typedef logic [1:0] req_t;
  localparam req_t REQ_LOAD  = 2'd0;
  localparam req_t REQ_START = 2'd1;
  localparam req_t REQ_CHAR  = 2'd2;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_FONT_SIZE = 2'd0;
  localparam cfg_idx_t CFG_FG_COLOR  = 2'd1;
  localparam cfg_idx_t CFG_BG_COLOR  = 2'd2;

  typedef logic [1:0] scale_t;
  localparam scale_t SIZE_SMALL   = 2'd0;
  localparam scale_t SIZE_REGULAR = 2'd1;
  localparam scale_t SIZE_LARGE   = 2'd2;
  localparam scale_t SIZE_TITLE   = 2'd3;

  localparam logic [7:0] NEWLINE_CODE  = 8'd10;
  localparam logic [6:0] QUESTION_CODE = 7'd63;

  // Source row for each output row of the 12-row and 24-row cells.
  localparam logic [3:0] SMALL_ROW [16] = '{
    4'd0, 4'd1, 4'd2, 4'd4, 4'd5, 4'd6, 4'd8, 4'd9,
    4'd10, 4'd12, 4'd13, 4'd14, 4'd0, 4'd0, 4'd0, 4'd0
  };
  localparam logic [3:0] LARGE_ROW [32] = '{
    4'd0, 4'd0, 4'd1, 4'd2, 4'd2, 4'd3, 4'd4, 4'd4,
    4'd5, 4'd6, 4'd6, 4'd7, 4'd8, 4'd8, 4'd9, 4'd10,
    4'd10, 4'd11, 4'd12, 4'd12, 4'd13, 4'd14, 4'd14, 4'd15,
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
  };

  function automatic logic [4:0] cell_width(scale_t size);
    logic [4:0] w;
    unique case (size)
      SIZE_SMALL:   w = 5'd6;
      SIZE_REGULAR: w = 5'd8;
      SIZE_LARGE:   w = 5'd12;
      SIZE_TITLE:   w = 5'd16;
      default:      w = 5'd8;
    endcase
    return w;
  endfunction

  function automatic logic [5:0] cell_height(scale_t size);
    logic [5:0] h;
    unique case (size)
      SIZE_SMALL:   h = 6'd12;
      SIZE_REGULAR: h = 6'd16;
      SIZE_LARGE:   h = 6'd24;
      SIZE_TITLE:   h = 6'd32;
      default:      h = 6'd16;
    endcase
    return h;
  endfunction

  function automatic logic [3:0] src_row(scale_t size, logic [4:0] row);
    logic [3:0] s;
    unique case (size)
      SIZE_SMALL:   s = SMALL_ROW[row[3:0]];
      SIZE_REGULAR: s = row[3:0];
      SIZE_LARGE:   s = LARGE_ROW[row];
      SIZE_TITLE:   s = row[4:1];
      default:      s = row[3:0];
    endcase
    return s;
  endfunction

  // Nearest-neighbour column expansion of one glyph row, bit 15 leftmost.
  function automatic logic [15:0] row_mask(scale_t size, logic [7:0] bits);
    logic [15:0] m;
    m = '0;
    unique case (size)
      SIZE_SMALL:   m = {bits[7], bits[6], bits[5], bits[3], bits[2], bits[1], 10'd0};
      SIZE_REGULAR: m = {bits, 8'd0};
      SIZE_LARGE:   m = {bits[7], bits[7], bits[6], bits[5], bits[5], bits[4],
                         bits[3], bits[3], bits[2], bits[1], bits[1], bits[0], 4'd0};
      SIZE_TITLE: begin
        for (int i = 0; i < 8; i++) begin
          m[15 - 2 * i] = bits[7 - i];
          m[14 - 2 * i] = bits[7 - i];
        end
      end
      default:      m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

@@ rtl/scaled_bitmap_text_renderer_top.sv @@
// Top level of the scaled bitmap text renderer: glyph memory, pen state and row span sequencer.
// Usage:
// Input items arrive on in_valid/in_stall and each transfer carries one request: a
// glyph row load, a text start that sets the origin, or a character. Loads, starts and
// newlines complete in the cycle of their transfer and produce nothing. A drawn
// character produces one row span per output row (12, 16, 24 or 32 by font_size) on
// out_valid/out_stall, the final one flagged by last_row.
// The first span of a character passes the row sequencer, the memory read stage and the
// output register. Throughput: spans leave at one per cycle unless out_stall holds them,
// each set by the single glyph memory read issued per output row; a character holds in_stall
// until its last row read is issued. Other requests enter every cycle while no character holds it.
// When the receiver stalls, the span in the output register is held, the read stage is
// filled by one row read if empty and held, and no further memory reads issue until it drains.
// Reset clears the pen, line start and all valid flags, sets font_size to regular and
// background painting off. Glyph memory contents are undefined until loaded.
// Configuration writes on cfg_we act at once; the user must make them only while idle.
`default_nettype none

module scaled_bitmap_text_renderer_top #(
  parameter int GLYPH_COUNT = sbtr_pkg::GLYPH_COUNT_DEF,
  parameter int COORD_BITS  = sbtr_pkg::COORD_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         req_type,
  input  wire logic [6:0]         load_glyph,
  input  wire logic [3:0]         load_row,
  input  wire logic [7:0]         load_bits,
  input  wire logic signed [15:0] origin_x,
  input  wire logic signed [15:0] origin_y,
  input  wire logic [7:0]         char_code,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      span_x,
  output logic signed [15:0]      span_y,
  output logic [15:0]             on_mask,
  output logic [4:0]              span_width,
  output logic                    paint_background,
  output logic                    last_row
);

  localparam int DEPTH = GLYPH_COUNT * sbtr_pkg::GLYPH_ROWS;
  localparam int AW    = $clog2(DEPTH);

  typedef logic [COORD_BITS-1:0] coord_t;

  // Configuration.
  sbtr_pkg::scale_t font_size;
  logic             bg_paint;

  // Pen state.
  coord_t pen_x;
  coord_t pen_y;
  coord_t line_x;

  // Row sequencer.
  logic             gen_active;
  logic [4:0]       row;
  logic [6:0]       gen_code;
  sbtr_pkg::scale_t gen_size;
  coord_t           gen_x;
  coord_t           gen_y;

  // Memory read stage.
  logic             s1_valid;
  logic [15:0]      s1_x;
  logic [15:0]      s1_y;
  sbtr_pkg::scale_t s1_size;
  logic             s1_last;
  logic [7:0]       rdata;

  logic [7:0] glyph_mem [DEPTH];

  logic        in_xfer;
  logic        out_xfer;
  logic        advance;
  logic        issue;
  logic        row_last;
  logic        mem_we;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [6:0]  draw_code;
  logic [31:0] ox_wide;
  logic [31:0] oy_wide;
  coord_t      row_y;
  logic [31:0] row_y_wide;
  logic [31:0] row_x_wide;
  logic [4:0]  char_w;
  logic [5:0]  char_h;
  logic        is_char;
  logic        is_newline;

  assign in_stall = gen_active;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign advance  = !out_valid || !out_stall;
  // A new row read goes out only when the read stage is free or moves on this cycle.
  assign issue    = gen_active && (!s1_valid || advance);
  assign row_last = ({1'b0, row} == (sbtr_pkg::cell_height(gen_size) - 6'd1));

  assign mem_we    = in_xfer && (req_type == sbtr_pkg::REQ_LOAD);
  assign wr_addr   = AW'({load_glyph, load_row});
  assign rd_addr   = AW'({gen_code, sbtr_pkg::src_row(gen_size, row)});
  assign draw_code = char_code[7] ? sbtr_pkg::QUESTION_CODE : char_code[6:0];

  assign ox_wide    = {{16{origin_x[15]}}, origin_x};
  assign oy_wide    = {{16{origin_y[15]}}, origin_y};
  assign row_y      = gen_y + COORD_BITS'(row);
  assign row_y_wide = 32'(row_y);
  assign row_x_wide = 32'(gen_x);

  assign char_w     = sbtr_pkg::cell_width(font_size);
  assign char_h     = sbtr_pkg::cell_height(font_size);
  assign is_char    = in_xfer && (req_type == sbtr_pkg::REQ_CHAR);
  assign is_newline = is_char && (char_code == sbtr_pkg::NEWLINE_CODE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      glyph_mem[wr_addr] <= load_bits;
    end
    if (issue) begin
      rdata <= glyph_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      font_size  <= sbtr_pkg::SIZE_REGULAR;
      bg_paint   <= 1'b0;
      pen_x      <= '0;
      pen_y      <= '0;
      line_x     <= '0;
      gen_active <= 1'b0;
      row        <= '0;
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          sbtr_pkg::CFG_FONT_SIZE: font_size <= cfg_data[1:0];
          // The foreground colour never reaches the span outputs.
          sbtr_pkg::CFG_FG_COLOR:  ;
          sbtr_pkg::CFG_BG_COLOR:  bg_paint <= |cfg_data;
          default:                 ;
        endcase
      end

      if (in_xfer && (req_type == sbtr_pkg::REQ_START)) begin
        pen_x  <= ox_wide[COORD_BITS-1:0];
        line_x <= ox_wide[COORD_BITS-1:0];
        pen_y  <= oy_wide[COORD_BITS-1:0];
      end else if (is_newline) begin
        pen_x <= line_x;
        pen_y <= pen_y + COORD_BITS'(char_h);
      end else if (is_char) begin
        pen_x <= pen_x + COORD_BITS'(char_w);
      end

      if (is_char && !is_newline) begin
        gen_active <= 1'b1;
        row        <= '0;
      end else if (issue) begin
        row <= row + 5'd1;
        if (row_last) begin
          gen_active <= 1'b0;
        end
      end

      if (issue) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end

      if (s1_valid && advance) begin
        out_valid <= 1'b1;
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_char && !is_newline) begin
      gen_code <= draw_code;
      gen_size <= font_size;
      gen_x    <= pen_x;
      gen_y    <= pen_y;
    end
    if (issue) begin
      s1_x    <= row_x_wide[15:0];
      s1_y    <= row_y_wide[15:0];
      s1_size <= gen_size;
      s1_last <= row_last;
    end
    if (s1_valid && advance) begin
      span_x           <= s1_x;
      span_y           <= s1_y;
      on_mask          <= sbtr_pkg::row_mask(s1_size, rdata);
      span_width       <= sbtr_pkg::cell_width(s1_size);
      paint_background <= bg_paint;
      last_row         <= s1_last;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sbtr_checker.sv @@
// Port-level checker for the bitmap text renderer, bound to the top level.
`default_nettype none

module sbtr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] span_x,
  input wire logic [15:0] span_y,
  input wire logic [15:0] on_mask,
  input wire logic [4:0]  span_width,
  input wire logic        paint_background,
  input wire logic        last_row
);

  // A stalled span must keep its contents.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(span_x) && $stable(span_y)
      && $stable(on_mask) && $stable(last_row))
    else $error("span changed while stalled");

  a_width_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> span_width == 5'd6 || span_width == 5'd8 || span_width == 5'd12
      || span_width == 5'd16)
    else $error("illegal span width");

  a_mask_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (span_width != 5'd6 || on_mask[9:0] == 10'd0)
      && (span_width != 5'd8 || on_mask[7:0] == 8'd0)
      && (span_width != 5'd12 || on_mask[3:0] == 4'd0))
    else $error("mask bits set beyond the span width");

  // Rows of one character follow back to back on the same column, one row lower.
  a_rows_follow: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_row |=> out_valid
      && span_x == $past(span_x) && span_y == $past(span_y) + 16'd1
      && span_width == $past(span_width) && paint_background == $past(paint_background))
    else $error("next row span of a character missing or misplaced");

endmodule

bind scaled_bitmap_text_renderer_top sbtr_checker u_sbtr_checker (.*);

`default_nettype wire
